// ===== design/mmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmq_pkg: shared types and constants of the min/max queue with counts
// Holds the store size, field widths, command and status codes, the item
// structs of both channels and the control struct that drives the cell rows.
// ----------------------------------------------------------------------------
package mmq_pkg;

    // Store size and value width.
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;

    // Derived widths: a cell index, and a count that can hold CAPACITY itself.
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int MULT_W = CNT_W;

    // Result field widths are fixed by the interface.
    localparam int ANSWER_W = 17;

    // Equality flags are reduced in registered groups of this size.
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // The flag vector padded out to a whole number of groups.
    localparam int PAD_W = NUM_GROUPS * GROUP_SIZE;

    localparam logic signed [ANSWER_W-1:0] ANSWER_NONE = '1;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_DIFF   = 2'd1,
        CMD_CNT_HI = 2'd2,
        CMD_CNT_LO = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GROUP,
        S_INSERT
    } t_state;

    // Operation broadcast to every cell of a row.
    typedef enum logic [1:0] {
        COP_HOLD,
        COP_CMP,
        COP_INSERT,
        COP_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cmd                  cmd;
        logic [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [ANSWER_W-1:0] answer;
        t_status                    status;
    } t_out_item;

    // One distinct value and how many copies of it are held.
    typedef struct packed {
        logic [VALUE_BITS-1:0] val;
        logic [MULT_W-1:0]     mult;
    } t_entry;

    // Control shared by all cells of one row.
    typedef struct packed {
        t_cell_op              op;
        logic                  descending;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_W-1:0]      count;
        logic                  found;
        logic                  dec_head;
        logic                  dec_tail;
        logic                  shift;
    } t_cell_ctrl;

endpackage

// ===== design/mmq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmq_cell: one slot of a sorted row
// Holds one distinct value with its multiplicity. On insert it keeps its
// entry, adds a copy, or takes the new value or its left neighbor's entry;
// on remove it takes its own or its right neighbor's entry after decrement.
// ----------------------------------------------------------------------------
module mmq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mmq_pkg::IDX_W-1:0] i_index,
    input  mmq_pkg::t_cell_ctrl       i_ctrl,
    input  mmq_pkg::t_entry           i_left,
    input  logic                      i_left_pre,
    input  mmq_pkg::t_entry           i_right_post,
    output mmq_pkg::t_entry           o_entry,
    output mmq_pkg::t_entry           o_post,
    output logic                      o_pre,
    output logic                      o_eq
);

    mmq_pkg::t_entry r_e;
    mmq_pkg::t_entry n_e;
    mmq_pkg::t_entry post;
    logic            r_pre;
    logic            n_pre;
    logic            r_eq;
    logic            n_eq;
    logic            in_use;
    logic            is_head;
    logic            is_tail;
    logic            precedes;
    logic            dec;

    // Position of this cell relative to the filled part of the row.
    assign in_use  = mmq_pkg::CNT_W'(i_index) < i_ctrl.count;
    assign is_head = (i_index == '0);
    assign is_tail = (mmq_pkg::CNT_W'(i_index) + mmq_pkg::CNT_W'(1)) == i_ctrl.count;

    // Does the held value sort ahead of the value being pushed?
    assign precedes = i_ctrl.descending ? (r_e.val > i_ctrl.value)
                                        : (r_e.val < i_ctrl.value);

    // Entry as it stands after a removal decrement.
    assign dec       = (is_head && i_ctrl.dec_head) || (is_tail && i_ctrl.dec_tail);
    assign post.val  = r_e.val;
    assign post.mult = r_e.mult - mmq_pkg::MULT_W'(dec);

    // Next entry and compare flags.
    always_comb begin
        n_e   = r_e;
        n_pre = r_pre;
        n_eq  = r_eq;
        unique case (i_ctrl.op)
            mmq_pkg::COP_CMP: begin
                n_pre = in_use && precedes;
                n_eq  = in_use && (r_e.val == i_ctrl.value);
            end
            mmq_pkg::COP_INSERT: begin
                if (i_ctrl.found) begin
                    if (r_eq) begin
                        n_e.mult = r_e.mult + mmq_pkg::MULT_W'(1);
                    end
                end else if (!r_pre) begin
                    if (is_head || i_left_pre) begin
                        n_e.val  = i_ctrl.value;
                        n_e.mult = mmq_pkg::MULT_W'(1);
                    end else begin
                        n_e = i_left;
                    end
                end
            end
            mmq_pkg::COP_REMOVE: begin
                n_e = i_ctrl.shift ? i_right_post : post;
            end
            default: begin
                n_e = r_e;
            end
        endcase
    end

    // Entry storage needs no reset; unused slots are never read.
    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    // Compare flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_pre <= n_pre;
            r_eq  <= n_eq;
        end
    end

    assign o_entry = r_e;
    assign o_post  = post;
    assign o_pre   = r_pre;
    assign o_eq    = r_eq;

endmodule

// ===== design/mmq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmq_chain: a sorted row of cells
// Links CAPACITY cells into a row kept in sort order, so that the row's
// extreme value always sits in cell zero. Exposes the head entry and the
// per-cell equality flags.
// ----------------------------------------------------------------------------
module mmq_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mmq_pkg::t_cell_ctrl          i_ctrl,
    output mmq_pkg::t_entry              o_head,
    output logic [mmq_pkg::CAPACITY-1:0] o_eq
);

    mmq_pkg::t_entry entry [mmq_pkg::CAPACITY];
    mmq_pkg::t_entry post  [mmq_pkg::CAPACITY];
    logic            pre   [mmq_pkg::CAPACITY];

    // Row of cells, each wired to both neighbors.
    for (genvar k = 0; k < mmq_pkg::CAPACITY; k++) begin : g_cell
        mmq_pkg::t_entry left;
        mmq_pkg::t_entry right_post;
        logic            left_pre;

        if (k == 0) begin : g_first
            assign left     = '0;
            assign left_pre = 1'b0;
        end else begin : g_inner_l
            assign left     = entry[k-1];
            assign left_pre = pre[k-1];
        end

        if (k == mmq_pkg::CAPACITY - 1) begin : g_last
            assign right_post = '0;
        end else begin : g_inner_r
            assign right_post = post[k+1];
        end

        mmq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (mmq_pkg::IDX_W'(k)),
            .i_ctrl       (i_ctrl),
            .i_left       (left),
            .i_left_pre   (left_pre),
            .i_right_post (right_post),
            .o_entry      (entry[k]),
            .o_post       (post[k]),
            .o_pre        (pre[k]),
            .o_eq         (o_eq[k])
        );
    end

    assign o_head = entry[0];

endmodule

// ===== design/min_max_queue_with_counts_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_queue_with_counts_unit: double-ended priority queue with counts
// Keeps up to CAPACITY values as distinct entries with multiplicities and
// answers max minus min (with removal) and the count of the max or the min.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A diff, a count query, or any command
// that is refused gives its result once the output is free; an accepted push
// passes the compare, group and insert states and gives no result. A push
// first searches for an existing copy of the value: every cell compares, the
// equality flags are reduced in registered groups of 32, and then all cells
// shift or count up. The store is held twice, in an ascending and a descending
// row of cells, so the minimum and the maximum each sit in the first cell of a
// row. A result waits in the output register while the next item is accepted.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_max_queue_with_counts_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mmq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mmq_pkg::t_out_item o_out
);

    mmq_pkg::t_state            r_state;
    mmq_pkg::t_state            n_state;
    mmq_pkg::t_cmd              r_cmd;
    logic [mmq_pkg::VALUE_BITS-1:0] r_v;
    logic [mmq_pkg::CNT_W-1:0]  r_count;
    logic [mmq_pkg::CNT_W-1:0]  n_count;
    logic [mmq_pkg::CNT_W-1:0]  r_items;
    logic [mmq_pkg::CNT_W-1:0]  n_items;
    logic [mmq_pkg::NUM_GROUPS-1:0] r_grp;
    logic                       r_out_valid;
    mmq_pkg::t_out_item         r_out;
    mmq_pkg::t_out_item         res;
    logic                       out_load;
    logic                       out_free;
    logic                       in_accept;
    logic                       empty;
    logic                       full;
    logic                       two_or_more;
    logic                       lo_gone;
    logic                       hi_gone;
    logic [mmq_pkg::VALUE_BITS-1:0] diff;
    mmq_pkg::t_cell_ctrl        asc_ctrl;
    mmq_pkg::t_cell_ctrl        desc_ctrl;
    mmq_pkg::t_entry            asc_head;
    mmq_pkg::t_entry            desc_head;
    logic [mmq_pkg::CAPACITY-1:0] asc_eq;
    logic [mmq_pkg::CAPACITY-1:0] desc_eq;
    logic [mmq_pkg::PAD_W-1:0]  eq_pad;

    // Ascending row: minimum in cell zero.
    mmq_chain u_asc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (asc_ctrl),
        .o_head  (asc_head),
        .o_eq    (asc_eq)
    );

    // Descending row: maximum in cell zero.
    mmq_chain u_desc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (desc_ctrl),
        .o_head  (desc_head),
        .o_eq    (desc_eq)
    );

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != mmq_pkg::S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Store status and the removal outcome of a diff.
    assign empty       = (r_items == '0);
    assign full        = (r_items >= mmq_pkg::CNT_W'(mmq_pkg::CAPACITY));
    assign two_or_more = (r_count > mmq_pkg::CNT_W'(1));
    assign lo_gone     = (asc_head.mult == mmq_pkg::MULT_W'(1));
    assign hi_gone     = two_or_more && (desc_head.mult == mmq_pkg::MULT_W'(1));
    assign diff        = desc_head.val - asc_head.val;

    // Both rows hold the same set, so the ascending row's flags decide a match.
    assign eq_pad = mmq_pkg::PAD_W'(asc_eq);

    // Registered group reduction of the equality flags.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < mmq_pkg::NUM_GROUPS; g++) begin
            r_grp[g] <= |eq_pad[g*mmq_pkg::GROUP_SIZE +: mmq_pkg::GROUP_SIZE];
        end
    end

    // Next state, row control and result.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_items  = r_items;
        out_load = 1'b0;
        res.answer = mmq_pkg::ANSWER_NONE;
        res.status = mmq_pkg::ST_OK;

        asc_ctrl.op         = mmq_pkg::COP_HOLD;
        asc_ctrl.descending = 1'b0;
        asc_ctrl.value      = r_v;
        asc_ctrl.count      = r_count;
        asc_ctrl.found      = |r_grp;
        asc_ctrl.dec_head   = 1'b0;
        asc_ctrl.dec_tail   = 1'b0;
        asc_ctrl.shift      = 1'b0;
        desc_ctrl            = asc_ctrl;
        desc_ctrl.descending = 1'b1;

        unique case (r_state)
            mmq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mmq_pkg::S_EXEC;
                end
            end
            mmq_pkg::S_EXEC: begin
                if (r_cmd == mmq_pkg::CMD_PUSH && !full) begin
                    asc_ctrl.op  = mmq_pkg::COP_CMP;
                    desc_ctrl.op = mmq_pkg::COP_CMP;
                    n_state      = mmq_pkg::S_GROUP;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = mmq_pkg::S_IDLE;
                    if (r_cmd == mmq_pkg::CMD_PUSH) begin
                        res.status = mmq_pkg::ST_FULL;
                    end else if (empty) begin
                        res.status = mmq_pkg::ST_EMPTY;
                    end else begin
                        case (r_cmd)
                            mmq_pkg::CMD_DIFF: begin
                                res.answer = mmq_pkg::ANSWER_W'(diff);
                                // Head of each row loses one copy; the tail
                                // loses one too when max and min differ.
                                asc_ctrl.op        = mmq_pkg::COP_REMOVE;
                                asc_ctrl.dec_head  = 1'b1;
                                asc_ctrl.dec_tail  = two_or_more;
                                asc_ctrl.shift     = lo_gone;
                                desc_ctrl.op       = mmq_pkg::COP_REMOVE;
                                desc_ctrl.dec_head = 1'b1;
                                desc_ctrl.dec_tail = two_or_more;
                                desc_ctrl.shift    =
                                    desc_head.mult == mmq_pkg::MULT_W'(1);
                                n_count = r_count - mmq_pkg::CNT_W'(lo_gone)
                                                  - mmq_pkg::CNT_W'(hi_gone);
                                n_items = r_items - mmq_pkg::CNT_W'(1)
                                                  - mmq_pkg::CNT_W'(two_or_more);
                            end
                            mmq_pkg::CMD_CNT_HI: begin
                                res.answer = mmq_pkg::ANSWER_W'(desc_head.mult);
                            end
                            default: begin
                                res.answer = mmq_pkg::ANSWER_W'(asc_head.mult);
                            end
                        endcase
                    end
                end
            end
            mmq_pkg::S_GROUP: begin
                n_state = mmq_pkg::S_INSERT;
            end
            mmq_pkg::S_INSERT: begin
                asc_ctrl.op  = mmq_pkg::COP_INSERT;
                desc_ctrl.op = mmq_pkg::COP_INSERT;
                n_items      = r_items + mmq_pkg::CNT_W'(1);
                n_count      = r_count + mmq_pkg::CNT_W'(!(|r_grp));
                n_state      = mmq_pkg::S_IDLE;
            end
            default: begin
                n_state = mmq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmq_pkg::S_IDLE;
            r_count     <= '0;
            r_items     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_items <= n_items;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_in.cmd;
            r_v   <= i_in.value;
        end
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Every distinct entry holds at least one copy.
    a_count_le_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_items)
        else $error("distinct count exceeds items held");

    // The store is empty in both counts or in neither.
    a_empty_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_items == '0) == (r_count == '0))
        else $error("item and distinct counts disagree on empty");

    // Never more items than the store can hold.
    a_items_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items <= mmq_pkg::CNT_W'(mmq_pkg::CAPACITY))
        else $error("items held exceeds capacity");

    // An accepted push that is not refused adds exactly one item.
    a_push_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmq_pkg::S_INSERT) |=> (r_items == $past(r_items) + mmq_pkg::CNT_W'(1)))
        else $error("insert did not add one item");

    // The rows both hold the same set, so their heads agree on order.
    a_heads_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmq_pkg::S_EXEC && r_count != '0) |-> (desc_head.val >= asc_head.val))
        else $error("maximum below minimum");

    // Both rows see the same set, so they agree on whether a pushed value is held.
    a_rows_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|asc_eq) == (|desc_eq))
        else $error("rows disagree on a held value");

endmodule
